FILE: rtl/core/sorted_task_priority_table_assert.svh
// Assertion shorthands used by the checker file.
`ifndef SORTED_TASK_PRIORITY_TABLE_ASSERT_SVH
`define SORTED_TASK_PRIORITY_TABLE_ASSERT_SVH

// Same-cycle implication.
`define STPT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define STPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/stpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stpt_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int TAG_BITS_DEF = 16;

   localparam int FIELD_BITS = 31;
   localparam int KEY_BITS   = 23;
   localparam int DATA_BITS  = 56;

   localparam logic [1:0] CMD_INSERT   = 2'd0;
   localparam logic [1:0] CMD_REMOVE   = 2'd1;
   localparam logic [1:0] CMD_READ     = 2'd2;
   localparam logic [1:0] CMD_EARLIEST = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;
   localparam logic [1:0] STAT_EMPTY = 2'd3;

   typedef struct packed {
      logic [7:0]  prio;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } task_fields_type;

   function automatic logic [KEY_BITS-1:0] date_key(input task_fields_type f);
      return {f.year, f.month, f.day};
   endfunction

   // true when a sorts strictly after b
   function automatic logic is_lower(input task_fields_type a, input task_fields_type b);
      logic lower;
      if (a.prio != b.prio) begin
         lower = a.prio < b.prio;
      end else begin
         lower = date_key(a) > date_key(b);
      end
      return lower;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/stpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stpt_ram
   import stpt_pkg::*;
#(
   parameter int WIDTH = TAG_BITS_DEF + FIELD_BITS,
   parameter int DEPTH = CAPACITY_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_task_priority_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Ports                         | Item
// req     | req_tvalid/tready/tdata/tuser | one table command
// rsp     | rsp_tvalid/tready/tdata/tuser | one result per command
//
// Earliest and an insert into a nonempty table read every held entry, remove
// reads from the position to the last entry, and read reads only its entry. An
// error or an insert into an empty table reads none. The next command waits for idle.
// Reset clears the entry count and handshake state; table contents stay.
// A new item is taken while a result waits; the next result holds until taken.

module sorted_task_priority_table
   import stpt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int TAG_BITS = TAG_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // task_tag[15:0], priority_req[23:16], due_day[28:24], due_month[32:29],
   // due_year[46:33], position[52:47], zero[55:53]
   input  wire logic [DATA_BITS-1:0] req_tdata,
   // command[1:0]
   input  wire logic [1:0]           req_tuser,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // out_tag[15:0], out_priority[23:16], out_day[28:24], out_month[32:29],
   // out_year[46:33], entry_count[53:47], zero[55:54]
   output logic      [DATA_BITS-1:0] rsp_tdata,
   // status[1:0]
   output logic      [1:0]           rsp_tuser
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = TAG_BITS + FIELD_BITS;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [1:0]            cmd_ff, cmd_in;
   logic [1:0]            status_ff, status_in;
   logic [TAG_BITS-1:0]   etag_ff, etag_in;
   task_fields_type       efld_ff, efld_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [AW-1:0]         last_ff, last_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic                  issue_ff, issue_in;
   logic                  dv_ff, dv_in;
   logic [AW-1:0]         didx_ff, didx_in;
   logic                  found_ff, found_in;
   logic [EW-1:0]         carry_ff, carry_in;
   logic [EW-1:0]         res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;

   logic                  we, re;
   logic [AW-1:0]         waddr;
   logic [EW-1:0]         wdata, rdata;
   task_fields_type       rd_fld, res_fld, req_fld;
   logic [TAG_BITS+15:0]  tag_in_ext, tag_out_ext;
   logic [CW+5:0]         pos_ext, cnt_ext;
   logic [CW+6:0]         cnt_out_ext;
   logic [CW-1:0]         cnt_after, cnt_m1;
   logic [5:0]            req_pos;
   logic                  pos_ok, count_zero, count_full, show;

   assign req_pos     = req_tdata[52:47];
   assign req_fld     = '{prio: req_tdata[23:16], year: req_tdata[46:33],
                          month: req_tdata[32:29], day: req_tdata[28:24]};
   assign tag_in_ext  = {{TAG_BITS{1'b0}}, req_tdata[15:0]};
   assign pos_ext     = {{CW{1'b0}}, req_pos};
   assign cnt_ext     = {6'b0, count_ff};
   assign pos_ok      = pos_ext < cnt_ext;
   assign count_zero  = count_ff == '0;
   assign count_full  = count_ff == CW'(CAPACITY);
   assign cnt_m1      = count_ff - CW'(1);
   assign rd_fld      = task_fields_type'(rdata[FIELD_BITS-1:0]);
   assign res_fld     = task_fields_type'(res_ff[FIELD_BITS-1:0]);
   assign tag_out_ext = {16'b0, res_ff[EW-1:FIELD_BITS]};
   assign cnt_out_ext = {7'b0, cnt_after};
   assign show        = (status_ff == STAT_OK) && (cmd_ff != CMD_INSERT);

   always_comb begin
      cnt_after = count_ff;
      if (status_ff == STAT_OK) begin
         case (cmd_ff)
            CMD_INSERT: cnt_after = count_ff + CW'(1);
            CMD_REMOVE: cnt_after = count_ff - CW'(1);
            default:    cnt_after = count_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      status_in    = status_ff;
      etag_in      = etag_ff;
      efld_in      = efld_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      addr_in      = addr_ff;
      issue_in     = issue_ff;
      dv_in        = 1'b0;
      didx_in      = didx_ff;
      found_in     = found_ff;
      carry_in     = carry_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      we           = 1'b0;
      waddr        = didx_ff;
      wdata        = rdata;
      re           = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               etag_in  = tag_in_ext[TAG_BITS-1:0];
               efld_in  = req_fld;
               pos_in   = pos_ext[AW-1:0];
               found_in = 1'b0;
               addr_in  = '0;
               last_in  = cnt_m1[AW-1:0];
               issue_in = 1'b1;
               status_in = STAT_OK;
               state_in = S_SCAN;
               unique case (req_tuser) inside
                  CMD_INSERT: begin
                     if (count_full) begin
                        status_in = STAT_FULL;
                        state_in  = S_DONE;
                     end else if (count_zero) begin
                        state_in = S_DONE;
                     end
                  end
                  CMD_REMOVE, CMD_READ: begin
                     addr_in = pos_ext[AW-1:0];
                     if (req_tuser == CMD_READ) begin
                        last_in = pos_ext[AW-1:0];
                     end
                     if (!pos_ok) begin
                        status_in = STAT_RANGE;
                        state_in  = S_DONE;
                     end
                  end
                  CMD_EARLIEST: begin
                     if (count_zero) begin
                        status_in = STAT_EMPTY;
                        state_in  = S_DONE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            re      = issue_ff;
            dv_in   = issue_ff;
            didx_in = addr_ff;
            if (issue_ff) begin
               addr_in = addr_ff + AW'(1);
               if (addr_ff == last_ff) begin
                  issue_in = 1'b0;
               end
            end
            if (dv_ff) begin
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (!found_ff && is_lower(rd_fld, efld_ff)) begin
                        we       = 1'b1;
                        wdata    = {etag_ff, efld_ff};
                        carry_in = rdata;
                        found_in = 1'b1;
                     end else if (found_ff) begin
                        we       = 1'b1;
                        wdata    = carry_ff;
                        carry_in = rdata;
                     end
                  end
                  CMD_REMOVE: begin
                     if (didx_ff == pos_ff) begin
                        res_in = rdata;
                     end else begin
                        we    = 1'b1;
                        waddr = didx_ff - AW'(1);
                     end
                  end
                  CMD_READ: res_in = rdata;
                  default: begin
                     if (didx_ff == '0 || date_key(rd_fld) < date_key(res_fld)) begin
                        res_in = rdata;
                     end
                  end
               endcase
               if (didx_ff == last_ff) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = show ?
                  {2'b0, cnt_out_ext[6:0], res_fld.year, res_fld.month, res_fld.day,
                   res_fld.prio, tag_out_ext[15:0]} :
                  {2'b0, cnt_out_ext[6:0], 47'b0};
               count_in = cnt_after;
               if (status_ff == STAT_OK && cmd_ff == CMD_INSERT) begin
                  we    = 1'b1;
                  waddr = count_ff[AW-1:0];
                  wdata = found_ff ? carry_ff : {etag_ff, efld_ff};
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      status_ff   <= status_in;
      etag_ff     <= etag_in;
      efld_ff     <= efld_in;
      pos_ff      <= pos_in;
      last_ff     <= last_in;
      addr_ff     <= addr_in;
      didx_ff     <= didx_in;
      found_ff    <= found_in;
      carry_ff    <= carry_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   stpt_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_en   (re),
      .rd_addr (addr_ff),
      .rd_data (rdata)
   );

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

FILE: rtl/core/stpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_task_priority_table_assert.svh"

module stpt_checker
   import stpt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_tvalid,
   input wire logic                 req_tready,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [DATA_BITS-1:0] rsp_tdata,
   input wire logic [1:0]           rsp_tuser
);

   `STPT_ASSERT_NEXT(a_req_gap, clock, reset, req_tvalid && req_tready,
      !req_tready, "input ready right after an item")

   `STPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled item changed")

   `STPT_ASSERT_IMPLY(a_empty_count, clock, reset, rsp_tvalid && (rsp_tuser == STAT_EMPTY),
      rsp_tdata[53:47] == 7'd0, "empty status with entries held")

   `STPT_ASSERT_IMPLY(a_full_count, clock, reset, rsp_tvalid && (rsp_tuser == STAT_FULL),
      rsp_tdata[53:47] == 7'(CAPACITY), "full status below capacity")

   `STPT_ASSERT_IMPLY(a_error_zero, clock, reset, rsp_tvalid && (rsp_tuser != STAT_OK),
      rsp_tdata[46:0] == 47'd0, "error item carries entry fields")

endmodule

bind sorted_task_priority_table stpt_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

`default_nettype wire
